/* rtl/shvrb_pkg.sv */
// Shared types, constants and byte-lane helpers for the SD host vendor register bank.
// Used by shvrb_decode, shvrb_regs and sd_host_vendor_register_bank; no dependencies.
package shvrb_pkg;

    // Default number of preset words.
    localparam int PRESET_COUNT_DEF = 3;

    // Window bases and sizes in the register space.
    localparam logic [9:0] CAP_BASE = 10'h040;
    localparam logic [9:0] CAP_END  = 10'h04C;
    localparam logic [9:0] PRE_BASE = 10'h060;
    localparam logic [9:0] PRE_END  = 10'h070;
    localparam logic [9:0] VEN_BASE = 10'h200;
    localparam logic [9:0] VEN_END  = 10'h244;
    localparam logic [4:0] CAP_SIZE = 5'd12;
    localparam logic [7:0] VEN_SIZE = 8'h44;

    // Vendor word indexes (byte offset from the vendor base divided by four).
    localparam logic [4:0] VW_STATUS = 5'h00;
    localparam logic [4:0] VW_MISC   = 5'h01;
    localparam logic [4:0] VW_AUX    = 5'h02;
    localparam logic [4:0] VW_CLK    = 5'h03;
    localparam logic [4:0] VW_CWE    = 5'h0C;
    localparam logic [4:0] VW_DEBUG  = 5'h0D;
    localparam logic [4:0] VW_CAL    = 5'h10;

    // Writable masks and fixed values.
    localparam logic [31:0] CAP_LO_MASK  = 32'hF700_FFBF;
    localparam logic [31:0] CAP_HI_MASK  = 32'h00FF_0077;
    localparam logic [31:0] MAX_CUR_MASK = 32'h00FF_FFFF;
    localparam logic [10:0] PRESET_MASK  = 11'h7FF;
    localparam logic [7:0]  MISC_MASK    = 8'hBB;
    localparam logic [31:0] KEY_MASK     = 32'h0000_FF00;
    localparam logic [31:0] KEY_VALUE    = 32'h0000_4600;
    localparam logic [4:0]  CAL_MASK     = 5'h1E;
    localparam logic [31:0] STATUS_VALUE = 32'h0000_000F;
    localparam logic [31:0] CAP_LO_RST   = 32'h27E8_32B2;
    localparam logic [31:0] CAP_HI_RST   = 32'h0001_0070;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_BAD    = 3'd1,
        ST_LOCKED = 3'd2,
        ST_RO     = 3'd3,
        ST_RSV    = 3'd4,
        ST_OUT    = 3'd5
    } t_status;

    // Register addressed by an access.
    typedef enum logic [3:0] {
        TG_NONE,
        TG_CAP_LO,
        TG_CAP_HI,
        TG_MAX_CUR,
        TG_PRESET,
        TG_V_STATUS,
        TG_V_MISC,
        TG_V_AUX,
        TG_V_CLK,
        TG_V_CWE,
        TG_V_DEBUG,
        TG_V_CAL
    } t_target;

    // Decoded access, passed from the decoder to the register file.
    typedef struct packed {
        t_target    target;
        t_status    status;
        logic [1:0] boff;
        logic [2:0] size;
        logic [2:0] pidx;
    } t_dec;

    // Byte lanes covered by an access of the given size at the given byte offset.
    function automatic logic [31:0] byte_lanes(input logic [1:0] boff, input logic [2:0] size);
        logic [31:0] m;
        case (size)
            3'd1:    m = 32'h0000_00FF << {boff, 3'b000};
            3'd2:    m = 32'h0000_FFFF << {boff, 3'b000};
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // Right-aligned read of the addressed lanes.
    function automatic logic [31:0] lane_pick(input logic [31:0] word, input logic [1:0] boff,
                                              input logic [2:0] size);
        return (word & byte_lanes(boff, size)) >> {boff, 3'b000};
    endfunction

    // Merge a right-aligned write value into the old word by byte lanes.
    function automatic logic [31:0] lane_merge(input logic [31:0] old, input logic [1:0] boff,
                                               input logic [31:0] val, input logic [2:0] size);
        logic [31:0] m;
        m = byte_lanes(boff, size);
        return (old & ~m) | ((val << {boff, 3'b000}) & m);
    endfunction

endpackage

/* rtl/sd_host_vendor_register_bank.sv */
// Top level of the SD host vendor register bank: input register, result register, handshakes.
// Depends on shvrb_pkg, shvrb_decode and shvrb_regs.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------------
//  access  | in        | i_in_valid / o_in_ready    | i_mode, i_address, i_access_bytes,
//          |           |                            | i_write_data
//  result  | out       | o_out_valid / i_out_ready  | o_read_data, o_status,
//          |           |                            | o_card_detect_forced, o_capability_*,
//          |           |                            | o_max_current_word
//
// An accepted item is held in the input register and moves into the result register when that
// register is free or being emptied; one item per cycle is sustained while the result side
// does not stall. Register state is updated at the same edge that loads the result, so each
// item sees the state left by the one before it. Synchronous active-low reset clears the
// vendor register state and both valid flags. A stalled result holds the input register,
// and input ready then drops.
module sd_host_vendor_register_bank import shvrb_pkg::*; #(
    parameter int PRESET_COUNT = PRESET_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [9:0]  i_address,
    input  logic [2:0]  i_access_bytes,
    input  logic [31:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_read_data,
    output logic [2:0]  o_status,
    output logic        o_card_detect_forced,
    output logic [31:0] o_capability_low,
    output logic [31:0] o_capability_high,
    output logic [23:0] o_max_current_word
);

    logic        r_in_valid;
    logic        r_mode;
    logic [9:0]  r_address;
    logic [2:0]  r_access_bytes;
    logic [31:0] r_write_data;
    logic        r_out_valid;
    logic [31:0] r_read_data;
    t_status     r_status;

    logic        advance;
    t_dec        dec;
    logic [31:0] n_read_data;
    t_status     n_status;

    // The held item moves on whenever the result register is free or being emptied.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_mode         <= i_mode;
            r_address      <= i_address;
            r_access_bytes <= i_access_bytes;
            r_write_data   <= i_write_data;
        end
    end

    shvrb_decode #(
        .PRESET_COUNT(PRESET_COUNT)
    ) u_decode (
        .i_address      (r_address),
        .i_access_bytes (r_access_bytes),
        .o_dec          (dec)
    );

    shvrb_regs #(
        .PRESET_COUNT(PRESET_COUNT)
    ) u_regs (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_en                 (advance),
        .i_dec                (dec),
        .i_mode               (r_mode),
        .i_write_data         (r_write_data),
        .o_read_data          (n_read_data),
        .o_status             (n_status),
        .o_card_detect_forced (o_card_detect_forced),
        .o_capability_low     (o_capability_low),
        .o_capability_high    (o_capability_high),
        .o_max_current_word   (o_max_current_word)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_read_data <= n_read_data;
            r_status    <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_status    = r_status;

`ifndef SYNTH
    // A rejected or failed access never returns data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_read_data == '0))
        else $error("non-ok result carries read data");

    // Status codes stay within the defined set.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_OUT))
        else $error("undefined status code");

    // Capability state changes only when an item is retired into the result register.
    a_cap_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(advance)) |->
            ($stable(o_capability_low) && $stable(o_capability_high)
             && $stable(o_max_current_word)))
        else $error("capability state changed without an item");

    // A held item is not dropped while the result side stalls.
    a_item_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("held item lost");
`endif

endmodule

/* rtl/shvrb_decode.sv */
// Address decoder: window selection, size and alignment checks, register selection.
// Depends on shvrb_pkg.
module shvrb_decode import shvrb_pkg::*; #(
    parameter int PRESET_COUNT = PRESET_COUNT_DEF
) (
    input  logic [9:0] i_address,
    input  logic [2:0] i_access_bytes,
    output t_dec       o_dec
);

    logic [3:0] cap_off;
    logic [3:0] pre_off;
    logic [6:0] ven_off;
    logic       size_ok;
    logic       align_ok;
    logic [2:0] low_off;

    // Offsets within each window.
    assign cap_off = 4'(i_address - CAP_BASE);
    assign pre_off = 4'(i_address - PRE_BASE);
    assign ven_off = 7'(i_address - VEN_BASE);

    assign size_ok = i_access_bytes inside {3'd1, 3'd2, 3'd4};

    // Window classification and register selection.
    always_comb begin
        o_dec        = '0;
        o_dec.target = TG_NONE;
        o_dec.status = ST_OUT;
        o_dec.size   = i_access_bytes;
        low_off      = i_address[2:0];
        align_ok     = (low_off & (i_access_bytes - 3'd1)) == 3'd0;
        o_dec.boff   = i_address[1:0];
        o_dec.pidx   = pre_off[3:1];

        if (i_address >= CAP_BASE && i_address < CAP_END) begin
            if (!size_ok || !align_ok || ({1'b0, cap_off} + {2'b00, i_access_bytes}) > CAP_SIZE) begin
                o_dec.status = ST_BAD;
            end else begin
                o_dec.status = ST_OK;
                case (cap_off[3:2])
                    2'd0:    o_dec.target = TG_CAP_LO;
                    2'd1:    o_dec.target = TG_CAP_HI;
                    default: o_dec.target = TG_MAX_CUR;
                endcase
            end
        end else if (i_address >= PRE_BASE && i_address < PRE_END) begin
            if (i_access_bytes != 3'd2 || pre_off[0]) begin
                o_dec.status = ST_BAD;
            end else if ({1'b0, pre_off[3:1]} >= 4'(PRESET_COUNT)) begin
                o_dec.status = ST_RSV;
            end else begin
                o_dec.status = ST_OK;
                o_dec.target = TG_PRESET;
            end
        end else if (i_address >= VEN_BASE && i_address < VEN_END) begin
            if (!size_ok || !align_ok || ({1'b0, ven_off} + {5'd0, i_access_bytes}) > VEN_SIZE) begin
                o_dec.status = ST_BAD;
            end else begin
                o_dec.status = ST_OK;
                case (ven_off[6:2])
                    VW_STATUS: o_dec.target = TG_V_STATUS;
                    VW_MISC:   o_dec.target = TG_V_MISC;
                    VW_AUX:    o_dec.target = TG_V_AUX;
                    VW_CLK:    o_dec.target = TG_V_CLK;
                    VW_CWE:    o_dec.target = TG_V_CWE;
                    VW_DEBUG:  o_dec.target = TG_V_DEBUG;
                    VW_CAL:    o_dec.target = TG_V_CAL;
                    default:   o_dec.status = ST_RSV;
                endcase
            end
        end
    end

endmodule

/* rtl/shvrb_regs.sv */
// Register file: holds all vendor state, forms read data and applies masked byte-lane writes.
// Depends on shvrb_pkg.
module shvrb_regs import shvrb_pkg::*; #(
    parameter int PRESET_COUNT = PRESET_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_dec        i_dec,
    input  logic        i_mode,
    input  logic [31:0] i_write_data,
    output logic [31:0] o_read_data,
    output t_status     o_status,
    output logic        o_card_detect_forced,
    output logic [31:0] o_capability_low,
    output logic [31:0] o_capability_high,
    output logic [23:0] o_max_current_word
);

    logic [31:0] r_cap_low;
    logic [31:0] r_cap_high;
    logic [23:0] r_max_current;
    logic [10:0] r_preset [PRESET_COUNT];
    logic [7:0]  r_misc;
    logic [1:0]  r_aux;
    logic        r_clk2;
    logic        r_cwe;
    logic        r_debug;
    logic [4:0]  r_cal;

    logic [31:0] n_cap_low;
    logic [31:0] n_cap_high;
    logic [23:0] n_max_current;
    logic [7:0]  n_misc;
    logic [1:0]  n_aux;
    logic        n_clk2;
    logic        n_cwe;
    logic        n_debug;
    logic [4:0]  n_cal;

    logic [31:0] old_word;
    logic [31:0] merged;
    logic [10:0] preset_rd;
    logic        preset_we;

    // Preset word read by index.
    always_comb begin
        preset_rd = '0;
        for (int g = 0; g < PRESET_COUNT; g++) begin
            if (i_dec.pidx == 3'(g)) begin
                preset_rd = r_preset[g];
            end
        end
    end

    // Current value of the addressed word.
    always_comb begin
        case (i_dec.target)
            TG_CAP_LO:   old_word = r_cap_low;
            TG_CAP_HI:   old_word = r_cap_high;
            TG_MAX_CUR:  old_word = {8'd0, r_max_current};
            TG_V_STATUS: old_word = STATUS_VALUE;
            TG_V_MISC:   old_word = {24'd0, r_misc};
            TG_V_AUX:    old_word = {30'd0, r_aux};
            TG_V_CLK:    old_word = {31'd0, r_clk2};
            TG_V_CWE:    old_word = {31'd0, r_cwe};
            TG_V_DEBUG:  old_word = {31'd0, r_debug};
            TG_V_CAL:    old_word = {27'd0, r_cal};
            default:     old_word = '0;
        endcase
    end

    assign merged = lane_merge(old_word, i_dec.boff, i_write_data, i_dec.size);

    // Read data, final status and next register values.
    always_comb begin
        o_read_data   = '0;
        o_status      = i_dec.status;
        preset_we     = 1'b0;
        n_cap_low     = r_cap_low;
        n_cap_high    = r_cap_high;
        n_max_current = r_max_current;
        n_misc        = r_misc;
        n_aux         = r_aux;
        n_clk2        = r_clk2;
        n_cwe         = r_cwe;
        n_debug       = r_debug;
        n_cal         = r_cal;

        if (i_dec.status == ST_OK) begin
            if (!i_mode) begin
                if (i_dec.target == TG_PRESET) begin
                    o_read_data = {21'd0, preset_rd};
                end else begin
                    o_read_data = lane_pick(old_word, i_dec.boff, i_dec.size);
                end
            end else begin
                case (i_dec.target)
                    TG_CAP_LO: begin
                        if (!r_cwe) o_status = ST_LOCKED;
                        else n_cap_low = (r_cap_low & ~CAP_LO_MASK) | (merged & CAP_LO_MASK);
                    end
                    TG_CAP_HI: begin
                        if (!r_cwe) o_status = ST_LOCKED;
                        else n_cap_high = (r_cap_high & ~CAP_HI_MASK) | (merged & CAP_HI_MASK);
                    end
                    TG_MAX_CUR: begin
                        if (!r_cwe) o_status = ST_LOCKED;
                        else n_max_current = merged[23:0];
                    end
                    TG_PRESET:   preset_we = 1'b1;
                    TG_V_STATUS: o_status = ST_RO;
                    TG_V_MISC:   n_misc = merged[7:0] & MISC_MASK;
                    TG_V_AUX:    n_aux = merged[1:0];
                    TG_V_CLK:    n_clk2 = merged[0];
                    TG_V_CWE: begin
                        // The lock bit moves only when the key sits in byte 1.
                        if ((merged & KEY_MASK) == KEY_VALUE) n_cwe = merged[0];
                    end
                    TG_V_DEBUG:  n_debug = merged[0];
                    TG_V_CAL:    n_cal = merged[4:0] & CAL_MASK;
                    default:     o_status = i_dec.status;
                endcase
            end
        end
    end

    // State update when the item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_low     <= CAP_LO_RST;
            r_cap_high    <= CAP_HI_RST;
            r_max_current <= '0;
            r_misc        <= '0;
            r_aux         <= '0;
            r_clk2        <= 1'b0;
            r_cwe         <= 1'b0;
            r_debug       <= 1'b0;
            r_cal         <= '0;
        end else if (i_en) begin
            r_cap_low     <= n_cap_low;
            r_cap_high    <= n_cap_high;
            r_max_current <= n_max_current;
            r_misc        <= n_misc;
            r_aux         <= n_aux;
            r_clk2        <= n_clk2;
            r_cwe         <= n_cwe;
            r_debug       <= n_debug;
            r_cal         <= n_cal;
        end
    end

    // Preset words, one write enable each.
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < PRESET_COUNT; g++) begin
            if (!i_rst_n) begin
                r_preset[g] <= '0;
            end else if (i_en && preset_we && i_dec.pidx == 3'(g)) begin
                r_preset[g] <= i_write_data[10:0] & PRESET_MASK;
            end
        end
    end

    assign o_card_detect_forced = r_misc[7];
    assign o_capability_low     = r_cap_low;
    assign o_capability_high    = r_cap_high;
    assign o_max_current_word   = r_max_current;

endmodule
